FILE: sv/port_knock_sequence_tracker_defines.svh
// -----------------------------------------------------------------------------
// Port knock sequence tracker: assertion macros
// Shared check forms, clocked on clk and held off while rst_n is low.
// -----------------------------------------------------------------------------
`ifndef PORT_KNOCK_SEQUENCE_TRACKER_DEFINES_SVH
`define PORT_KNOCK_SEQUENCE_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PKTR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PKTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pktr_pkg.sv
// -----------------------------------------------------------------------------
// Port knock sequence tracker package
// Types, register indexes and constants shared by the tracker modules.
// -----------------------------------------------------------------------------
package pktr_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 64;
    localparam int SEQ_LEN               = 3;
    localparam int CFG_INDEX_W           = 2;
    localparam int CFG_DATA_W            = 32;
    localparam int TIMEOUT_W             = 16;
    localparam int SLOT_OUT_W            = 6;

    localparam logic [31:0]          WORD_FIRST_RESET  = 32'd1;
    localparam logic [31:0]          WORD_SECOND_RESET = 32'd2;
    localparam logic [31:0]          WORD_THIRD_RESET  = 32'd3;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 16'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WORD_FIRST  = 2'd0,
        CFG_WORD_SECOND = 2'd1,
        CFG_WORD_THIRD  = 2'd2,
        CFG_TIMEOUT     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        OUT_NO_SLOT  = 2'd0,
        OUT_MISMATCH = 2'd1,
        OUT_ADVANCED = 2'd2,
        OUT_COMPLETE = 2'd3
    } outcome_t;

    typedef struct packed {
        logic [31:0] client_addr;
        logic [31:0] message_code;
        logic [31:0] current_time;
    } knock_req_t;

    typedef struct packed {
        logic [1:0]            outcome;
        logic [SLOT_OUT_W-1:0] slot_index;
        logic                  timed_out;
        logic [1:0]            progress_after;
    } knock_res_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  progress;
        logic [31:0] last_seen;
    } entry_t;

    // Verdict of the update unit for one knock.
    typedef struct packed {
        outcome_t    outcome;
        logic        timed_out;
        logic [1:0]  progress;
    } eval_t;

endpackage

FILE: sv/pktr_entry_ram.sv
// -----------------------------------------------------------------------------
// Port knock client table
// One-write, one-read memory of client entries with registered read data.
// -----------------------------------------------------------------------------
module pktr_entry_ram #(
    parameter int DEPTH = pktr_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [IDX_W-1:0]      wr_addr,
    input  pktr_pkg::entry_t      wr_data,
    input  logic                  rd_en,
    input  logic [IDX_W-1:0]      rd_addr,
    output pktr_pkg::entry_t      rd_data
);
    import pktr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/pktr_knock_eval.sv
// -----------------------------------------------------------------------------
// Port knock update unit
// Applies the timeout and the expected-word match to one client entry.
// -----------------------------------------------------------------------------
module pktr_knock_eval (
    input  logic [1:0]                      progress,
    input  logic [31:0]                     last_seen,
    input  logic [31:0]                     current_time,
    input  logic [31:0]                     message_code,
    input  logic [31:0]                     word_first,
    input  logic [31:0]                     word_second,
    input  logic [31:0]                     word_third,
    input  logic [pktr_pkg::TIMEOUT_W-1:0]  timeout,
    output pktr_pkg::eval_t                 verdict
);
    import pktr_pkg::*;

    logic [31:0] elapsed;
    logic        expired;
    logic [1:0]  base_progress;
    logic [31:0] expected;

    always_comb
    begin
        // Elapsed time wraps modulo 2^32.
        elapsed = current_time - last_seen;
        expired = elapsed > {{(32 - TIMEOUT_W){1'b0}}, timeout};

        if (expired || progress >= 2'(SEQ_LEN))
        begin
            base_progress = 2'd0;
        end
        else
        begin
            base_progress = progress;
        end

        unique case (base_progress)
            2'd0:    expected = word_first;
            2'd1:    expected = word_second;
            default: expected = word_third;
        endcase

        verdict.timed_out = expired;
        if (message_code != expected)
        begin
            verdict.outcome  = OUT_MISMATCH;
            verdict.progress = 2'd0;
        end
        else if (base_progress == 2'(SEQ_LEN - 1))
        begin
            verdict.outcome  = OUT_COMPLETE;
            verdict.progress = 2'd0;
        end
        else
        begin
            verdict.outcome  = OUT_ADVANCED;
            verdict.progress = base_progress + 2'd1;
        end
    end

endmodule

FILE: sv/port_knock_sequence_tracker.sv
// -----------------------------------------------------------------------------
// Port knock sequence tracker
// Looks up each knock's client in a table, applies the timeout and steps the
// client through a three-word knock sequence.
// -----------------------------------------------------------------------------
//  channel   signals                          handshake
//  request   start, request                   taken when start && !busy
//  result    done, result                     one-cycle strobe, no stall
//  config    cfg_write, cfg_index, cfg_data   written when cfg_write is high
//
//  The table memory gives one entry a cycle to the address compare, and the
//  S_UPDATE state then writes the entry and registers the result. A request
//  that hits scans the slots in order up to the match. A miss reads every
//  occupied slot, drains the last read and then claims the next free slot
//  (straight away on an empty table). With all 64 slots occupied a miss
//  reports no free slot after the last read drains.
//  Reset empties the table at once through the fill count; no clearing pass.
//  busy stays high until the cycle done is shown; results cannot be held off.
// -----------------------------------------------------------------------------
`include "port_knock_sequence_tracker_defines.svh"

module port_knock_sequence_tracker #(
    parameter int TABLE_ENTRIES = pktr_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  pktr_pkg::knock_req_t              request,
    output logic                              busy,
    output logic                              done,
    output pktr_pkg::knock_res_t              result,
    input  logic                              cfg_write,
    input  logic [pktr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pktr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pktr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    state_t               state_reg;
    knock_req_t           req_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     fill_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pend_idx_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [1:0]           hit_progress_reg;
    logic [31:0]          hit_seen_reg;
    logic                 done_reg;
    knock_res_t           result_reg;

    logic [31:0]          word_first_reg;
    logic [31:0]          word_second_reg;
    logic [31:0]          word_third_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    logic                 rd_en;
    entry_t               rd_data;
    logic                 hit;
    logic                 wr_en;
    entry_t               wr_data;
    eval_t                verdict;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_first_reg  <= WORD_FIRST_RESET;
            word_second_reg <= WORD_SECOND_RESET;
            word_third_reg  <= WORD_THIRD_RESET;
            timeout_reg     <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WORD_FIRST:  word_first_reg  <= cfg_data[31:0];
                CFG_WORD_SECOND: word_second_reg <= cfg_data[31:0];
                CFG_WORD_THIRD:  word_third_reg  <= cfg_data[31:0];
                CFG_TIMEOUT:     timeout_reg     <= cfg_data[TIMEOUT_W-1:0];
            endcase
        end
    end

    assign rd_en = (state_reg == S_SCAN) && !hit && (idx_reg < fill_reg);
    assign hit   = pend_reg && (rd_data.addr == req_reg.client_addr);
    assign wr_en = (state_reg == S_UPDATE);

    always_comb
    begin
        wr_data.addr      = req_reg.client_addr;
        wr_data.progress  = verdict.progress;
        wr_data.last_seen = req_reg.current_time;
    end

    pktr_entry_ram #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    pktr_knock_eval u_eval (
        .progress     (hit_progress_reg),
        .last_seen    (hit_seen_reg),
        .current_time (req_reg.current_time),
        .message_code (req_reg.message_code),
        .word_first   (word_first_reg),
        .word_second  (word_second_reg),
        .word_third   (word_third_reg),
        .timeout      (timeout_reg),
        .verdict      (verdict)
    );

    // Sequencer: scan, then update the found or claimed slot, or report no free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= request;
                        idx_reg   <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    priority if (hit)
                    begin
                        slot_reg         <= pend_idx_reg;
                        hit_progress_reg <= rd_data.progress;
                        hit_seen_reg     <= rd_data.last_seen;
                        pend_reg         <= 1'b0;
                        state_reg        <= S_UPDATE;
                    end
                    else if (rd_en)
                    begin
                        pend_reg     <= 1'b1;
                        pend_idx_reg <= idx_reg[IDX_W-1:0];
                        idx_reg      <= idx_reg + 1'b1;
                    end
                    else if (pend_reg)
                    begin
                        // last read came back without a match
                        pend_reg <= 1'b0;
                    end
                    else if (fill_reg == FULL_COUNT)
                    begin
                        result_reg.outcome        <= OUT_NO_SLOT;
                        result_reg.slot_index     <= '0;
                        result_reg.timed_out      <= 1'b0;
                        result_reg.progress_after <= 2'd0;
                        done_reg                  <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                    else
                    begin
                        // claim the next free slot; elapsed time is zero
                        slot_reg         <= fill_reg[IDX_W-1:0];
                        hit_progress_reg <= 2'd0;
                        hit_seen_reg     <= req_reg.current_time;
                        fill_reg         <= fill_reg + 1'b1;
                        state_reg        <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    result_reg.outcome        <= verdict.outcome;
                    result_reg.slot_index     <= SLOT_OUT_W'(slot_reg);
                    result_reg.timed_out      <= verdict.timed_out;
                    result_reg.progress_after <= verdict.progress;
                    done_reg                  <= 1'b1;
                    state_reg                 <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `PKTR_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while still busy")
    `PKTR_ASSERT_NEXT(a_start_busy, start && !busy, busy || done,
        "accepted request did not start a scan")
    `PKTR_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= FULL_COUNT, "fill count beyond table")
    `PKTR_ASSERT_SAME(a_no_slot_full, done && result.outcome == OUT_NO_SLOT,
        fill_reg == FULL_COUNT, "no-slot result with free slots left")
    `PKTR_ASSERT_SAME(a_complete_restart, done && result.outcome == OUT_COMPLETE,
        result.progress_after == 2'd0, "completed sequence did not restart progress")

endmodule
